// ===== hdl/lmep_pkg.sv =====
// Shared types, codes and word-packing helpers for the list-mode event packer.
// Used by lmep_ctrl, lmep_datapath and the top level; no dependencies.
`default_nettype none

package lmep_pkg;

    localparam int NUM_MODULES_DEF = 5;
    localparam int QUEUE_WORDS_DEF = 4096;
    localparam int MAX_BURST_DEF   = 64;

    localparam int WORD_W  = 32;
    localparam int LEVEL_W = 13;
    localparam int TS_W    = 48;

    localparam logic [1:0] KIND_WRITE = 2'd0;
    localparam logic [1:0] KIND_READ  = 2'd1;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_BAD  = 2'd2;

    localparam logic [1:0] RATE_100 = 2'd0;
    localparam logic [1:0] RATE_250 = 2'd1;

    localparam logic [2:0] HDR_LEN = 3'd4;
    localparam logic [2:0] EVT_LEN = 3'd4;
    localparam int         EVENT_WORDS = 4;

    // commands from controller to datapath
    typedef struct packed {
        logic load;     // capture a new item
        logic prep;     // latch pointers and counts for the item
        logic resp;     // emit the single status result
        logic step_wr;  // write one event word
        logic step_rd;  // read one queue word
    } dp_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic bad;
        logic is_write;
        logic is_read;
        logic full;
        logic rd_empty;
        logic wr_last;
        logic rd_last;
    } dp_stat_t;

    function automatic logic [WORD_W-1:0] make_header(
        input logic [3:0] channel,
        input logic [3:0] slot,
        input logic [3:0] crate
    );
        logic [WORD_W-1:0] w;
        w = '0;
        w[3:0]   = channel;
        w[7:4]   = slot;
        w[11:8]  = crate;
        w[14:12] = HDR_LEN;
        w[19:17] = EVT_LEN;
        return w;
    endfunction

    function automatic logic [WORD_W-1:0] make_time_hi(
        input logic [15:0] ts_hi,
        input logic [14:0] cfd_fraction,
        input logic [2:0]  cfd_src,
        input logic [1:0]  rate_mode
    );
        logic [WORD_W-1:0] w;
        w = '0;
        w[15:0] = ts_hi;
        unique case (rate_mode)
            RATE_100: w[30:16] = cfd_fraction;
            RATE_250:
            begin
                w[29:16] = cfd_fraction[13:0];
                w[30]    = cfd_src[0];
            end
            default:
            begin
                w[28:16] = cfd_fraction[12:0];
                w[31:29] = cfd_src;
            end
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/lmep_ctrl.sv =====
// Sequencing state machine for the list-mode event packer.
// Depends on lmep_pkg for the command and status structs.
`default_nettype none

module lmep_ctrl (
    input  wire              clk,
    input  wire              rst_n,
    input  wire              start,
    output logic             busy,
    input  lmep_pkg::dp_stat_t stat,
    output lmep_pkg::dp_cmd_t  cmd
);
    import lmep_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EVAL,
        S_WRITE,
        S_READ
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   single_result;

    assign busy = (state_reg != S_IDLE);

    // one status result ends the item: bad index, full queue, empty read, query
    assign single_result = stat.bad || (stat.is_write && stat.full)
                         || (stat.is_read && stat.rd_empty)
                         || (!stat.is_write && !stat.is_read);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.load = start;
                if (start)
                begin
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                cmd.prep = 1'b1;
                if (single_result)
                begin
                    cmd.resp   = 1'b1;
                    state_next = S_IDLE;
                end
                else if (stat.is_write)
                begin
                    state_next = S_WRITE;
                end
                else
                begin
                    state_next = S_READ;
                end
            end
            S_WRITE:
            begin
                cmd.step_wr = 1'b1;
                if (stat.wr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_READ:
            begin
                cmd.step_rd = 1'b1;
                if (stat.rd_last)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/lmep_datapath.sv =====
// Datapath of the list-mode event packer: item registers, per-module ring
// pointers and fill levels, the word store and the result registers.
// Depends on lmep_pkg.
`default_nettype none

module lmep_datapath #(
    parameter int NUM_MODULES = lmep_pkg::NUM_MODULES_DEF,
    parameter int QUEUE_WORDS = lmep_pkg::QUEUE_WORDS_DEF,
    parameter int MAX_BURST   = lmep_pkg::MAX_BURST_DEF
) (
    input  wire                          clk,
    input  wire                          rst_n,
    input  lmep_pkg::dp_cmd_t            cmd,
    output lmep_pkg::dp_stat_t           stat,
    input  wire  [1:0]                   kind,
    input  wire  [2:0]                   module_req,
    input  wire  [3:0]                   channel,
    input  wire  [3:0]                   slot,
    input  wire  [3:0]                   crate,
    input  wire  [lmep_pkg::TS_W-1:0]    timestamp,
    input  wire  [14:0]                  cfd_fraction,
    input  wire  [2:0]                   cfd_src,
    input  wire  [1:0]                   rate_mode,
    input  wire  [15:0]                  energy,
    input  wire  [6:0]                   read_count,
    output logic                         result_valid,
    output logic [lmep_pkg::WORD_W-1:0]  word,
    output logic                         word_valid,
    output logic                         last,
    output logic [1:0]                   status,
    output logic [lmep_pkg::LEVEL_W-1:0] level
);
    import lmep_pkg::*;

    localparam int MW    = (NUM_MODULES > 1) ? $clog2(NUM_MODULES) : 1;
    localparam int PW    = $clog2(QUEUE_WORDS);
    localparam int LW    = $clog2(QUEUE_WORDS + 1);
    localparam int XW    = (LW > 7) ? LW : 7;
    localparam int DEPTH = NUM_MODULES * QUEUE_WORDS;
    localparam int AW    = $clog2(DEPTH);

    // captured item
    logic [1:0]        kind_reg;
    logic [2:0]        mod_reg;
    logic [3:0]        channel_reg;
    logic [3:0]        slot_reg;
    logic [3:0]        crate_reg;
    logic [TS_W-1:0]   ts_reg;
    logic [14:0]       cfd_reg;
    logic [2:0]        src_reg;
    logic [1:0]        rate_reg;
    logic [15:0]       energy_reg;
    logic [6:0]        rcnt_reg;

    // per-module queue state
    logic [LW-1:0]     fill_reg [NUM_MODULES];
    logic [PW-1:0]     rptr_reg [NUM_MODULES];

    // per-item working registers
    logic [PW-1:0]     pos_reg;
    logic [AW-1:0]     base_reg;
    logic [1:0]        widx_reg;
    logic [6:0]        rem_reg;
    logic [LW-1:0]     lvl_after_reg;

    logic [WORD_W-1:0] mem [DEPTH];
    logic [WORD_W-1:0] rd_data_reg;

    logic                res_valid_reg;
    logic                res_wvalid_reg;
    logic                res_last_reg;
    logic [1:0]          res_status_reg;
    logic [LEVEL_W-1:0]  res_level_reg;

    logic [MW-1:0]     midx;
    logic [LW-1:0]     lvl;
    logic [PW-1:0]     rp;
    logic              bad;
    logic              full;
    logic [6:0]        rc_burst;
    logic [6:0]        cnt;
    logic [PW:0]       wr_sum;
    logic [PW-1:0]     wr_start;
    logic [PW-1:0]     pos_inc;
    logic [AW-1:0]     addr;
    logic [WORD_W-1:0] wdata;

    assign midx = mod_reg[MW-1:0];
    assign lvl  = fill_reg[midx];
    assign rp   = rptr_reg[midx];
    assign bad  = ({1'b0, mod_reg} >= 4'(NUM_MODULES));
    assign full = ((LW+1)'(lvl) + (LW+1)'(EVENT_WORDS)) > (LW+1)'(QUEUE_WORDS);

    // clamp the request to the burst limit, then to the fill level
    assign rc_burst = (rcnt_reg > 7'(MAX_BURST)) ? 7'(MAX_BURST) : rcnt_reg;
    assign cnt      = (XW'(rc_burst) > XW'(lvl)) ? 7'(lvl) : rc_burst;

    // ring position of the first free word
    assign wr_sum   = (PW+1)'(rp) + (PW+1)'(lvl);
    assign wr_start = (wr_sum >= (PW+1)'(QUEUE_WORDS))
                    ? PW'(wr_sum - (PW+1)'(QUEUE_WORDS)) : PW'(wr_sum);
    assign pos_inc  = (pos_reg == PW'(QUEUE_WORDS - 1)) ? '0 : PW'(pos_reg + 1'b1);
    assign addr     = base_reg + AW'(pos_reg);

    always_comb
    begin
        case (widx_reg)
            2'd0:    wdata = make_header(channel_reg, slot_reg, crate_reg);
            2'd1:    wdata = ts_reg[31:0];
            2'd2:    wdata = make_time_hi(ts_reg[47:32], cfd_reg, src_reg, rate_reg);
            default: wdata = {16'd0, energy_reg};
        endcase
    end

    always_comb
    begin
        stat          = '0;
        stat.bad      = bad;
        stat.is_write = (kind_reg == KIND_WRITE);
        stat.is_read  = (kind_reg == KIND_READ);
        stat.full     = full;
        stat.rd_empty = (cnt == 7'd0);
        stat.wr_last  = (widx_reg == 2'(EVENT_WORDS - 1));
        stat.rd_last  = (rem_reg == 7'd1);
    end

    // capture item and per-item working values
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg    <= kind;
            mod_reg     <= module_req;
            channel_reg <= channel;
            slot_reg    <= slot;
            crate_reg   <= crate;
            ts_reg      <= timestamp;
            cfd_reg     <= cfd_fraction;
            src_reg     <= cfd_src;
            rate_reg    <= rate_mode;
            energy_reg  <= energy;
            rcnt_reg    <= read_count;
        end
        if (cmd.prep)
        begin
            pos_reg       <= (kind_reg == KIND_WRITE) ? wr_start : rp;
            base_reg      <= AW'(midx) * AW'(QUEUE_WORDS);
            widx_reg      <= 2'd0;
            rem_reg       <= cnt;
            lvl_after_reg <= lvl - LW'(cnt);
        end
        if (cmd.step_wr || cmd.step_rd)
        begin
            pos_reg <= pos_inc;
        end
        if (cmd.step_wr)
        begin
            widx_reg <= widx_reg + 2'd1;
        end
        if (cmd.step_rd)
        begin
            rem_reg <= rem_reg - 7'd1;
        end
    end

    // word store: one write or one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (cmd.step_wr)
        begin
            mem[addr] <= wdata;
        end
        if (cmd.step_rd)
        begin
            rd_data_reg <= mem[addr];
        end
    end

    // queue pointers and fill levels, committed on the final word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_MODULES; i++)
            begin
                fill_reg[i] <= '0;
                rptr_reg[i] <= '0;
            end
        end
        else
        begin
            if (cmd.step_wr && stat.wr_last)
            begin
                fill_reg[midx] <= lvl + LW'(EVENT_WORDS);
            end
            if (cmd.step_rd && stat.rd_last)
            begin
                fill_reg[midx] <= lvl_after_reg;
                rptr_reg[midx] <= pos_inc;
            end
        end
    end

    // result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg  <= 1'b0;
            res_wvalid_reg <= 1'b0;
            res_last_reg   <= 1'b0;
            res_status_reg <= ST_OK;
            res_level_reg  <= '0;
        end
        else
        begin
            if (cmd.resp)
            begin
                res_valid_reg  <= 1'b1;
                res_wvalid_reg <= 1'b0;
                res_last_reg   <= 1'b1;
                if (bad)
                begin
                    res_status_reg <= ST_BAD;
                    res_level_reg  <= '0;
                end
                else
                begin
                    res_status_reg <= (kind_reg == KIND_WRITE) ? ST_FULL : ST_OK;
                    res_level_reg  <= LEVEL_W'(lvl);
                end
            end
            else if (cmd.step_wr && stat.wr_last)
            begin
                res_valid_reg  <= 1'b1;
                res_wvalid_reg <= 1'b0;
                res_last_reg   <= 1'b1;
                res_status_reg <= ST_OK;
                res_level_reg  <= LEVEL_W'(lvl + LW'(EVENT_WORDS));
            end
            else if (cmd.step_rd)
            begin
                res_valid_reg  <= 1'b1;
                res_wvalid_reg <= 1'b1;
                res_last_reg   <= stat.rd_last;
                res_status_reg <= ST_OK;
                res_level_reg  <= LEVEL_W'(lvl_after_reg);
            end
            else
            begin
                res_valid_reg  <= 1'b0;
                res_wvalid_reg <= 1'b0;
            end
        end
    end

    assign result_valid = res_valid_reg;
    assign word         = res_wvalid_reg ? rd_data_reg : '0;
    assign word_valid   = res_wvalid_reg;
    assign last         = res_last_reg;
    assign status       = res_status_reg;
    assign level        = res_level_reg;

endmodule

`default_nettype wire

// ===== hdl/list_mode_event_packer_fifo_unit.sv =====
// Top level of the list-mode event packer: one word queue per module.
// Instantiates lmep_ctrl and lmep_datapath; depends on lmep_pkg.
`default_nettype none

// Usage
//   Command channel: an item is taken at a rising edge with start high and
//   busy low. kind selects write event, read words or query level (kind 3
//   acts as a query). busy stays high while the item is worked on.
//   Result channel: each result word sits on word/word_valid/last/status/
//   level for exactly one cycle with result_valid high. There is no
//   backpressure; the receiver must take every word as it comes.
// Sequencing
//   The item is registered on acceptance and evaluated in the next cycle.
//   Status-only results (bad module, full queue, empty read, query) are
//   registered as the block returns to idle, ready to take a new item.
//   An event write goes through the single store write port, one word per
//   cycle; the result is registered with the final word as the block
//   returns to idle. A read of N words issues one store read per cycle:
//   words appear on consecutive cycles from the registered store output,
//   and the block returns to idle with the last word.
// Reset
//   Reset clears every read pointer and fill level, so all queues are empty.
//   The word store is not cleared; only written words are ever drained.
module list_mode_event_packer_fifo_unit #(
    parameter int NUM_MODULES = lmep_pkg::NUM_MODULES_DEF,
    parameter int QUEUE_WORDS = lmep_pkg::QUEUE_WORDS_DEF,
    parameter int MAX_BURST   = lmep_pkg::MAX_BURST_DEF
) (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          start,
    output logic                         busy,
    input  wire  [1:0]                   kind,
    input  wire  [2:0]                   module_req,
    input  wire  [3:0]                   channel,
    input  wire  [3:0]                   slot,
    input  wire  [3:0]                   crate,
    input  wire  [lmep_pkg::TS_W-1:0]    timestamp,
    input  wire  [14:0]                  cfd_fraction,
    input  wire  [2:0]                   cfd_src,
    input  wire  [1:0]                   rate_mode,
    input  wire  [15:0]                  energy,
    input  wire  [6:0]                   read_count,
    output logic                         result_valid,
    output logic [lmep_pkg::WORD_W-1:0]  word,
    output logic                         word_valid,
    output logic                         last,
    output logic [1:0]                   status,
    output logic [lmep_pkg::LEVEL_W-1:0] level
);
    import lmep_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // sequence load, evaluate, write or read bursts
    lmep_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .stat  (stat),
        .cmd   (cmd)
    );

    // hold item, queue state, word store and result registers
    lmep_datapath #(
        .NUM_MODULES (NUM_MODULES),
        .QUEUE_WORDS (QUEUE_WORDS),
        .MAX_BURST   (MAX_BURST)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .kind         (kind),
        .module_req   (module_req),
        .channel      (channel),
        .slot         (slot),
        .crate        (crate),
        .timestamp    (timestamp),
        .cfd_fraction (cfd_fraction),
        .cfd_src      (cfd_src),
        .rate_mode    (rate_mode),
        .energy       (energy),
        .read_count   (read_count),
        .result_valid (result_valid),
        .word         (word),
        .word_valid   (word_valid),
        .last         (last),
        .status       (status),
        .level        (level)
    );

`ifndef ASSERT_OFF
    // a drained word always comes with an ok status
    a_word_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && word_valid) |-> (status == ST_OK))
        else $error("drained word with error status");

    // a bad module index reports an empty level and no data, and ends the item
    a_bad_idx: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && status == ST_BAD) |-> (level == '0 && !word_valid && last))
        else $error("bad index result malformed");

    // a burst runs without gaps until its last word
    a_burst: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !last) |=> (result_valid && word_valid))
        else $error("gap inside read burst");

    // an accepted item always raises busy
    a_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("item accepted without going busy");
`endif

endmodule

`default_nettype wire
